[design/elcsr_pkg.sv]
`timescale 1ns / 1ps
package elcsr_pkg;
    localparam int NODES = 1024;
    localparam int EDGES = 4096;
    localparam int NODE_W = 10;
    localparam int SLOT_W = 12;
    localparam int CNT_W = 13;
    localparam int CFG_W = 13;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_BUILD = 2'd1,
        OP_QUERY = 2'd2,
        OP_READ  = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_NODE = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    localparam logic CFG_HIGHEST = 1'b0;
    localparam logic CFG_CAPACITY = 1'b1;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [NODE_W-1:0] source_node;
        logic [NODE_W-1:0] target_node;
        logic [SLOT_W-1:0] slot_index;
    } t_req;

    typedef struct packed {
        logic [1:0]        status;
        logic [CNT_W-1:0]  out_degree;
        logic [CNT_W-1:0]  in_degree;
        logic [CNT_W-1:0]  first_slot;
        logic [NODE_W-1:0] slot_source;
        logic [NODE_W-1:0] slot_target;
        logic              is_sorted;
    } t_rsp;
endpackage

[design/elcsr_if.sv]
`timescale 1ns / 1ps
interface elcsr_req_if;
    import elcsr_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface elcsr_rsp_if;
    import elcsr_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[design/edge_list_to_csr_builder.sv]
`timescale 1ns / 1ps
// Edge list to CSR builder.
// Requests arrive as beats on i_req (opcode, source, target, slot); every
// request produces exactly one response beat on o_rsp. Configuration is a
// plain write port: i_cfg_we, i_cfg_idx (0 highest_node, 1 edge_capacity)
// and i_cfg_data, written only while the block is idle: the user must keep
// to this; the block itself does not enforce it. Add, query and slot read
// pass through S_RD, which issues the memory reads, S_WB, which modifies and
// writes back on the registered read data and loads the response register,
// and S_RESP, which raises the response. A new request is taken while the
// response waits, but none while one is still in S_RD, S_WB or S_RESP.
// A build walks all NODES counters (prefix sum, a read and a write state a
// node through the shared node memory port), then every stored edge twice
// (scatter into scratch through read, pointer and write back states, then
// copy back through read and write states); a build while sorted skips them.
// Reset clears the counters by a sweep over all NODES entries of the node
// memory, during which no request is accepted. When the receiver stalls,
// the response is held in the output register; one more request may be
// taken, and it waits before its write back until the register is free.
module edge_list_to_csr_builder (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_idx,
    input  logic [elcsr_pkg::CFG_W-1:0] i_cfg_data,
    elcsr_req_if.sink              i_req,
    elcsr_rsp_if.source            o_rsp
);
    import elcsr_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD, S_WB, S_RESP,
        S_PS_RD, S_PS_WB, S_SC_RD, S_SC_PT, S_SC_WB, S_CP_RD, S_CP_WB
    } t_state;

    // Node memory: out count, in count, row start, place pointer per node.
    logic [CNT_W-1:0] m_out [NODES];
    logic [CNT_W-1:0] m_in  [NODES];
    logic [CNT_W-1:0] m_row [NODES];
    logic [CNT_W-1:0] m_ptr [NODES];
    // Edge memories: store and scratch.
    logic [2*NODE_W-1:0] m_edge [EDGES];
    logic [2*NODE_W-1:0] m_scr  [EDGES];

    t_state r_state;
    t_req   r_req;
    t_rsp   r_rsp;
    t_rsp   n_rsp;
    logic   r_rsp_valid;
    logic [NODE_W-1:0] r_hi;
    logic [CFG_W-1:0]  r_cap;
    logic [CNT_W-1:0]  r_ecount;
    logic              r_sorted;
    logic [CNT_W-1:0]  r_run;
    logic [CNT_W-1:0]  r_i;
    logic [NODE_W-1:0] r_node;

    // Read ports (registered data).
    logic [NODE_W-1:0] n_na, n_nb;
    logic [SLOT_W-1:0] n_ea, n_sa;
    logic [CNT_W-1:0]  r_out_a, r_in_b, r_row_a, r_ptr_a;
    logic [2*NODE_W-1:0] r_edge_q, r_scr_q;

    logic src_ok, dst_ok, add_ok;
    logic [CFG_W-1:0] lim;

    assign src_ok = (r_req.source_node <= r_hi);
    assign dst_ok = (r_req.target_node <= r_hi);
    assign lim = (r_cap < CFG_W'(EDGES)) ? r_cap : CFG_W'(EDGES);
    assign add_ok = src_ok && dst_ok && (r_ecount < lim);

    always_comb begin
        n_na = r_req.source_node;
        // A query reads the in count of its own node on port b.
        n_nb = (r_req.opcode == OP_QUERY) ? r_req.source_node : r_req.target_node;
        n_ea = r_req.slot_index;
        n_sa = r_i[SLOT_W-1:0];
        unique case (r_state)
            S_PS_RD: n_na = r_node;
            S_SC_RD, S_CP_RD: begin
                n_ea = r_i[SLOT_W-1:0];
            end
            S_SC_PT: begin
                n_na = r_edge_q[2*NODE_W-1:NODE_W];
                n_ea = r_i[SLOT_W-1:0];
            end
            default: ;
        endcase
    end

    // Response contents, formed from the registered read data.
    always_comb begin
        n_rsp = '0;
        unique case (t_opcode'(r_req.opcode))
            OP_ADD: begin
                if (!src_ok || !dst_ok) n_rsp.status = ST_NODE;
                else if (!add_ok) n_rsp.status = ST_FULL;
            end
            OP_BUILD: ;
            OP_QUERY: begin
                if (!src_ok) n_rsp.status = ST_NODE;
                else begin
                    n_rsp.out_degree = r_out_a;
                    n_rsp.in_degree  = r_in_b;
                    n_rsp.first_slot = r_row_a;
                end
            end
            OP_READ: begin
                if (CNT_W'(r_req.slot_index) >= r_ecount)
                    n_rsp.status = ST_FULL;
                else begin
                    n_rsp.slot_source = r_edge_q[2*NODE_W-1:NODE_W];
                    n_rsp.slot_target = r_edge_q[NODE_W-1:0];
                end
            end
            default: ;
        endcase
        // An accepted add clears the sorted flag at the same edge as its write back.
        n_rsp.is_sorted = (r_req.opcode == OP_ADD && add_ok) ? 1'b0 : r_sorted;
    end

    always_ff @(posedge i_clk) begin
        r_out_a  <= m_out[n_na];
        r_row_a  <= m_row[n_na];
        r_ptr_a  <= m_ptr[n_na];
        r_in_b   <= m_in[n_nb];
        r_edge_q <= m_edge[n_ea];
        r_scr_q  <= m_scr[n_sa];
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_rsp_valid;
    assign o_rsp.data  = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_rsp_valid <= 1'b0;
            r_req       <= '0;
            r_hi        <= NODE_W'(NODES - 1);
            r_cap       <= CFG_W'(EDGES);
            r_ecount    <= '0;
            r_sorted    <= 1'b1;
            r_node      <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_HIGHEST) r_hi <= i_cfg_data[NODE_W-1:0];
                else r_cap <= i_cfg_data;
            end
            if (o_rsp.valid && o_rsp.ready) r_rsp_valid <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    m_out[r_node] <= '0;
                    m_in[r_node]  <= '0;
                    m_row[r_node] <= '0;
                    r_node <= r_node + 1'b1;
                    if (r_node == NODE_W'(NODES - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_req.valid && i_req.ready) begin
                        r_req   <= i_req.data;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    // Node out of range is only the register check: ids fit NODES.
                    if (r_rsp_valid && !o_rsp.ready) begin
                        // The previous response still occupies the output register.
                        r_state <= S_RD;
                    end else if (r_req.opcode == OP_BUILD) begin
                        if (r_sorted) r_state <= S_WB;
                        else begin
                            r_node  <= '0;
                            r_run   <= '0;
                            r_state <= S_PS_RD;
                        end
                    end else r_state <= S_WB;
                end
                S_WB: begin
                    r_rsp <= n_rsp;
                    if (r_req.opcode == OP_ADD && add_ok) begin
                        m_edge[r_ecount[SLOT_W-1:0]] <=
                            {r_req.source_node, r_req.target_node};
                        m_out[r_req.source_node] <= r_out_a + 1'b1;
                        // Self loop: in count read on port b stays valid.
                        m_in[r_req.target_node] <= r_in_b + 1'b1;
                        r_ecount <= r_ecount + 1'b1;
                        r_sorted <= 1'b0;
                    end
                    r_state <= S_RESP;
                end
                S_RESP: begin
                    r_rsp_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_PS_RD: r_state <= S_PS_WB;
                S_PS_WB: begin
                    m_row[r_node] <= r_run;
                    m_ptr[r_node] <= r_run + r_out_a;
                    r_run  <= r_run + r_out_a;
                    r_node <= r_node + 1'b1;
                    r_i    <= '0;
                    if (r_node == NODE_W'(NODES - 1))
                        r_state <= (r_ecount == '0) ? S_CP_RD : S_SC_RD;
                    else r_state <= S_PS_RD;
                end
                S_SC_RD: r_state <= S_SC_PT;
                S_SC_PT: r_state <= S_SC_WB;
                S_SC_WB: begin
                    if (r_ptr_a != '0) begin
                        m_scr[SLOT_W'(r_ptr_a - 1'b1)] <= r_edge_q;
                        m_ptr[r_edge_q[2*NODE_W-1:NODE_W]] <= r_ptr_a - 1'b1;
                    end
                    if (r_i + 1'b1 >= r_ecount) begin
                        r_i <= '0;
                        r_state <= S_CP_RD;
                    end else begin
                        r_i <= r_i + 1'b1;
                        r_state <= S_SC_RD;
                    end
                end
                S_CP_RD: begin
                    if (r_i >= r_ecount) begin
                        r_sorted <= 1'b1;
                        r_state  <= S_WB;
                    end else r_state <= S_CP_WB;
                end
                S_CP_WB: begin
                    m_edge[r_i[SLOT_W-1:0]] <= r_scr_q;
                    r_i <= r_i + 1'b1;
                    r_state <= S_CP_RD;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // The build must not add or drop any stored edge: the count never moves.
    a_count_build: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SC_WB || r_state == S_CP_WB) |=> $stable(r_ecount))
        else $error("edge count changed during build");
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("second request accepted while one in flight");
    a_resp_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESP) |=> r_rsp_valid)
        else $error("response not raised");
    a_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ecount <= CNT_W'(EDGES))
        else $error("edge count above store size");
endmodule
